// ===== sv/fpsqrt_pkg.sv =====
`default_nettype none
package fpsqrt_pkg;

  localparam int FRAC_BITS = 32;
  localparam int WORD_BITS = 64;

  localparam int HALF_FRAC = FRAC_BITS / 2;
  // integer root of a WORD_BITS operand
  localparam int ROOT_INT_W = WORD_BITS / 2;
  localparam int ROOT_W = 48;
  localparam int INV_W = 49;

  // one / (r << HALF_FRAC) equals 2^DIV_SHIFT / r after truncation
  localparam int DIV_SHIFT = 2 * FRAC_BITS - HALF_FRAC;
  localparam int DIV_STEPS = DIV_SHIFT + 1;

  localparam int SQ_CNT_W = $clog2(ROOT_INT_W + 1);
  localparam int DV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef logic [ROOT_INT_W-1:0] root_int_t;
  typedef logic [INV_W-1:0] inv_t;

endpackage
`default_nettype wire

// ===== sv/fpsqrt_root.sv =====
`default_nettype none
module fpsqrt_root
  import fpsqrt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [WORD_BITS-1:0] operand,
  output logic                      done,
  output root_int_t                 root
);

  logic [WORD_BITS-1:0]    op_r;
  logic [ROOT_INT_W+1:0]   rem_r;
  root_int_t               root_r;
  logic [SQ_CNT_W-1:0]     cnt_r;
  logic                    busy_r;
  logic                    done_r;

  logic [ROOT_INT_W+1:0]   rem_sh;
  logic [ROOT_INT_W+1:0]   trial;
  logic                    ge;
  logic [ROOT_INT_W+1:0]   rem_nxt;
  root_int_t               root_nxt;

  // bring down the next two operand bits and try a one digit
  always_comb begin
    rem_sh   = {rem_r[ROOT_INT_W-1:0], op_r[WORD_BITS-1 -: 2]};
    trial    = {root_r, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[ROOT_INT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= operand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        op_r   <= {op_r[WORD_BITS-3:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r + SQ_CNT_W'(1);
        if (cnt_r == SQ_CNT_W'(ROOT_INT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ===== sv/fpsqrt_div.sv =====
`default_nettype none
module fpsqrt_div
  import fpsqrt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  root_int_t divisor,
  output logic      done,
  output inv_t      quotient
);

  root_int_t             d_r;
  root_int_t             rem_r;
  inv_t                  q_r;
  logic [DV_CNT_W-1:0]   cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [ROOT_INT_W:0]   rem_sh;
  logic                  ge;
  logic [ROOT_INT_W:0]   diff;
  root_int_t             rem_nxt;

  // dividend is a lone one bit, fed in on the first step only
  always_comb begin
    rem_sh  = {rem_r, (cnt_r == '0)};
    ge      = (rem_sh >= {1'b0, d_r});
    diff    = rem_sh - {1'b0, d_r};
    rem_nxt = ge ? diff[ROOT_INT_W-1:0] : rem_sh[ROOT_INT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        d_r    <= divisor;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        // drop quotient bits that fall off the top of the field
        q_r   <= {q_r[INV_W-2:0], ge};
        cnt_r <= cnt_r + DV_CNT_W'(1);
        if (cnt_r == DV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

// ===== sv/fixed_point_sqrt_and_inverse_sqrt_top.sv =====
`default_nettype none
// Fixed-point square root and inverse square root. One item at a time: an
// item is computed by the bit-serial root at two operand bits per cycle,
// then by the restoring divide of one by the root at one quotient bit per
// cycle, then handed over to the output register. A zero or negative
// operand skips the root and the divide and returns zeros with
// nonpositive_input set. The input is taken again once the current item
// has moved to the output register, even while that result still waits
// on out_stall.
module fixed_point_sqrt_and_inverse_sqrt_top
  import fpsqrt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [63:0] in_raw_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ROOT_W-1:0]       out_root,
  output logic [INV_W-1:0]        out_inverse_root,
  output logic                    out_nonpositive_input
);

  typedef enum logic [1:0] {S_IDLE, S_ROOT, S_DIV, S_DONE} state_t;

  state_t               state_r;
  logic                 np_r;
  logic                 out_valid_r;
  logic [ROOT_W-1:0]    out_root_r;
  inv_t                 out_inv_r;
  logic                 out_np_r;

  logic [WORD_BITS-1:0] word;
  logic                 nonpos;
  logic                 accept;
  logic                 load;
  logic                 root_done;
  root_int_t            root_int;
  logic                 div_done;
  inv_t                 quot;
  logic [ROOT_W+ROOT_INT_W+HALF_FRAC-1:0] root_wide;

  assign word     = in_raw_value[WORD_BITS-1:0];
  assign nonpos   = (word == '0) || word[WORD_BITS-1];
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load     = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign root_wide = {{ROOT_W{1'b0}}, root_int, {HALF_FRAC{1'b0}}};

  fpsqrt_root u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept && !nonpos),
    .operand (word),
    .done    (root_done),
    .root    (root_int)
  );

  fpsqrt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_done),
    .divisor  (root_int),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            np_r    <= nonpos;
            state_r <= nonpos ? S_DONE : S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_done) state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state_r <= S_DONE;
        end
        S_DONE: begin
          if (load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      if (load) begin
        out_valid_r <= 1'b1;
        out_root_r  <= np_r ? '0 : root_wide[ROOT_W-1:0];
        out_inv_r   <= np_r ? '0 : quot;
        out_np_r    <= np_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_root              = out_root_r;
  assign out_inverse_root      = out_inv_r;
  assign out_nonpositive_input = out_np_r;

endmodule
`default_nettype wire

// ===== test/tb_fixed_point_sqrt_and_inverse_sqrt_top.sv =====
`default_nettype none
module tb_fixed_point_sqrt_and_inverse_sqrt_top
  import fpsqrt_pkg::*;
;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_PRINTED = 40;
  // largest integer root of a positive 64-bit operand
  localparam logic [63:0] MAX_ROOT_INT = 64'd3037000499;

  typedef enum int {PACE_NONE, PACE_MIXED, PACE_HEAVY} pace_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [INV_W-1:0]  inverse_root;
    logic              nonpositive;
  } sqrt_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [63:0] in_raw_value = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [ROOT_W-1:0] out_root;
  logic [INV_W-1:0] out_inverse_root;
  logic out_nonpositive_input;

  sqrt_result_t pending_results[$];
  sqrt_result_t oldest;
  int mismatches = 0;
  int cycle_count = 0;
  int stall_left = 0;
  pace_t send_pace = PACE_MIXED;
  pace_t recv_pace = PACE_MIXED;

  fixed_point_sqrt_and_inverse_sqrt_top i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_raw_value          (in_raw_value),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_root              (out_root),
    .out_inverse_root      (out_inverse_root),
    .out_nonpositive_input (out_nonpositive_input)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Floor root found bit by bit from the top, then one over the shifted root.
  function automatic sqrt_result_t predict_sqrt(input logic [63:0] raw);
    sqrt_result_t res;
    logic [63:0] word;
    logic [63:0] trial;
    logic [63:0] root_int;
    logic [63:0] root_fixed;
    logic [127:0] quotient;
    word = raw & ((64'd1 << WORD_BITS) - 64'd1);
    res = '0;
    if (word == 64'd0 || word[WORD_BITS-1]) begin
      res.nonpositive = 1'b1;
      return res;
    end
    root_int = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root_int | (64'd1 << b);
      if (trial * trial <= word)
        root_int = trial;
    end
    root_fixed = root_int << HALF_FRAC;
    quotient = (128'd1 << (2 * FRAC_BITS)) / {64'd0, root_fixed};
    res.root = root_fixed[ROOT_W-1:0];
    res.inverse_root = quotient[INV_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Record each accepted item, then match each accepted result to the oldest.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pending_results.push_back(predict_sqrt(in_raw_value));
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        oldest = pending_results.pop_front();
        if (out_root !== oldest.root)
          report_mismatch($sformatf("root %0h, want %0h", out_root, oldest.root));
        if (out_inverse_root !== oldest.inverse_root)
          report_mismatch($sformatf("inverse_root %0h, want %0h",
                                    out_inverse_root, oldest.inverse_root));
        if (out_nonpositive_input !== oldest.nonpositive)
          report_mismatch($sformatf("nonpositive_input %b, want %b",
                                    out_nonpositive_input, oldest.nonpositive));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver back-pressure: mostly short stalls, a few long ones.
  always @(posedge clk) begin
    logic stall_now;
    int pick;
    stall_now = 1'b0;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      stall_now = 1'b1;
    end else if (recv_pace != PACE_NONE) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        stall_now = 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else if (pick < ((recv_pace == PACE_HEAVY) ? 40 : 28)) begin
        stall_now = 1'b1;
        stall_left <= $urandom_range(20, 120);
      end
    end
    out_stall <= stall_now;
  end

  function automatic int pick_gap();
    int pick;
    if (send_pace == PACE_NONE)
      return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      return 0;
    if (pick < (send_pace == PACE_HEAVY ? 75 : 90))
      return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Valid stays high across back-to-back items; drop it only for a gap.
  task automatic send_operand(input logic [63:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    logic [63:0] r;
    case ($urandom_range(0, 9))
      0, 1, 2: v = {$urandom, $urandom};
      3, 4, 5: v = {1'b0, 63'({$urandom, $urandom})} >> $urandom_range(0, 62);
      6, 7: begin
        r = {32'd0, $urandom} >> $urandom_range(0, 31);
        if (r > MAX_ROOT_INT)
          r = MAX_ROOT_INT;
        v = r * r + 64'($urandom_range(0, 2)) - 64'd1;
      end
      8: v = -({1'b0, 63'({$urandom, $urandom})} >> $urandom_range(0, 62));
      default: begin
        case ($urandom_range(0, 3))
          0: v = 64'd0;
          1: v = 64'd1;
          2: v = 64'h7fff_ffff_ffff_ffff;
          default: v = 64'h8000_0000_0000_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic test_directed();
    logic [63:0] corner[$];
    corner = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'hffff_ffff_ffff_ffff,
               64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
               64'h7fff_ffff_ffff_ffff, 64'h0000_0001_0000_0000,
               64'h0000_0000_ffff_ffff, 64'h0000_0000_0000_ffff,
               64'h0000_0000_0001_0000, 64'h3fff_ffff_ffff_ffff,
               64'h4000_0000_0000_0000, MAX_ROOT_INT * MAX_ROOT_INT,
               MAX_ROOT_INT * MAX_ROOT_INT - 64'd1, 64'h5555_5555_5555_5555,
               64'haaaa_aaaa_aaaa_aaaa, 64'd8, 64'd9, 64'hffff_ffff_ffff_fffe};
    foreach (corner[i])
      send_operand(corner[i]);
    drain_results();
  endtask

  task automatic test_random_mixed(input int count);
    send_pace = PACE_MIXED;
    recv_pace = PACE_MIXED;
    repeat (count) send_operand(random_operand());
  endtask

  // Let the pipeline empty completely between bursts.
  task automatic test_drain_between_bursts(input int bursts, input int per_burst);
    repeat (bursts) begin
      repeat (per_burst) send_operand(random_operand());
      drain_results();
    end
  endtask

  task automatic test_no_idling(input int count);
    send_pace = PACE_NONE;
    recv_pace = PACE_NONE;
    repeat (count) send_operand(random_operand());
    drain_results();
  endtask

  task automatic test_heavy_idling(input int count);
    send_pace = PACE_HEAVY;
    recv_pace = PACE_HEAVY;
    repeat (count) send_operand(random_operand());
    drain_results();
    send_pace = PACE_MIXED;
    recv_pace = PACE_MIXED;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mixed(600);
    test_drain_between_bursts(3, 50);
    test_no_idling(150);
    test_heavy_idling(150);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== fixed_point_sqrt_and_inverse_sqrt_top.f =====
sv/fpsqrt_pkg.sv
sv/fpsqrt_root.sv
sv/fpsqrt_div.sv
sv/fixed_point_sqrt_and_inverse_sqrt_top.sv
test/tb_fixed_point_sqrt_and_inverse_sqrt_top.sv
